// ===== src/qbd_pkg.sv =====
// Shared types, codes and float helpers for the quantized block dequantizer.
// No dependencies; used by qbd_fpu and quantized_block_dequantizer.
`default_nettype none

package qbd_pkg;

    typedef enum logic [1:0] {
        FMT_Q8_0 = 2'd0,
        FMT_Q5_0 = 2'd1,
        FMT_Q6_K = 2'd2,
        FMT_Q4_K = 2'd3
    } t_fmt;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DRAIN,
        ST_CALC
    } t_state;

    typedef enum logic {
        FOP_MUL,
        FOP_SUB
    } t_fpu_op;

    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] F32_ZERO = 32'h0000_0000;

    // Exact widening of a half to single precision.
    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic        s;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  p;
        logic [32:0] t;
        s = h[15];
        e = h[14:10];
        m = h[9:0];
        p = '0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) p = 4'(i);
        end
        t = {m, 23'b0} >> p;
        if (e == 5'd0) begin
            if (m == 10'd0) return F32_ZERO;
            return {s, 8'(8'd103 + 8'(p)), t[22:0]};
        end
        if (e == 5'h1F) begin
            if (m != 10'd0) return F32_QNAN;
            return {s, 8'hFF, 23'd0};
        end
        return {s, 8'(8'(e) + 8'd112), m, 13'd0};
    endfunction

    // Small signed integer to single precision (always exact).
    function automatic logic [31:0] int_to_f32(input logic signed [8:0] v);
        logic        s;
        logic [8:0]  a;
        logic [3:0]  p;
        logic [31:0] t;
        s = v[8];
        a = s ? 9'(-v) : 9'(v);
        p = '0;
        for (int i = 0; i < 9; i++) begin
            if (a[i]) p = 4'(i);
        end
        t = {a, 23'b0} >> p;
        if (a == 9'd0) return F32_ZERO;
        return {s, 8'(8'd127 + 8'(p)), t[22:0]};
    endfunction

endpackage

`default_nettype wire

// ===== src/quantized_block_dequantizer.sv =====
// Top level of the quantized block dequantizer: byte store, fetch sequencer,
// operand decode and step control of the shared float unit. Uses qbd_pkg, qbd_fpu.
//
// A write request (tuser 0) stores one byte and the port stays ready. A read
// request (tuser 1) fetches its bytes from the byte store one per cycle (3 for
// Q8_0, 4 for Q5_0, 5 for Q6_K, 8 for Q4_K), passes through a drain state for
// the registered read, then runs 1, 1, 2 or 4 steps through the one shared
// multiply/subtract unit for Q8_0, Q5_0, Q6_K and Q4_K. The input is not ready
// while a read is in work. The result sits in an output register, so the next
// request is taken while it waits. The store has no reset; the format
// register resets to Q8_0.
`default_nettype none

module quantized_block_dequantizer
    import qbd_pkg::*;
#(
    parameter int BLOCK_BYTES = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // [7:0] byte_addr, [15:8] byte_value, [23:16] elem_index
    input  wire  [0:0]  s_axis_tuser,   // [0] op
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value_bits
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(BLOCK_BYTES);

    t_state      r_state, n_state;
    t_fmt        r_fmt;
    logic [2:0]  r_k, n_k;
    logic [1:0]  r_c, n_c;
    logic [7:0]  r_e;
    logic [7:0]  r_mem [BLOCK_BYTES];
    logic [7:0]  r_rdata;
    logic [7:0]  r_b [8];
    logic        r_fv;
    logic [2:0]  r_fk;
    logic [31:0] r_acc, r_tmp;
    logic        r_ovalid;
    logic [31:0] r_odata;

    logic        acc_in, acc_out;
    logic [7:0]  rd_addr;
    logic [2:0]  last_k;
    logic        last_c;

    // operand decode
    logic [15:0]       dh, dm;
    logic signed [8:0] x0, x1, x2;
    logic [4:0]        off;
    logic [1:0]        sub6;
    logic [2:0]        sb4;
    logic [3:0]        nib4;
    logic [5:0]        sc4, m4;

    t_fpu_op     f_op;
    logic [31:0] f_a, f_b, f_y;

    assign acc_in  = s_axis_tvalid && s_axis_tready;
    assign acc_out = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign pready        = 1'b1;
    assign prdata        = {30'd0, r_fmt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_Q8_0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_fmt <= t_fmt'(pwdata[1:0]);
        end
    end

    // fetch address of slot r_k
    always_comb begin
        off  = r_e[4:0];
        sub6 = r_e[6:5];
        sb4  = r_e[7:5];
        unique case (r_fmt)
            FMT_Q8_0: begin
                last_k = 3'd2;
                unique case (r_k)
                    3'd0:    rd_addr = 8'd0;
                    3'd1:    rd_addr = 8'd1;
                    default: rd_addr = 8'd2 + 8'(off);
                endcase
            end
            FMT_Q5_0: begin
                last_k = 3'd3;
                unique case (r_k)
                    3'd0:    rd_addr = 8'd0;
                    3'd1:    rd_addr = 8'd1;
                    3'd2:    rd_addr = 8'd2 + 8'(off[4:3]);
                    default: rd_addr = 8'd6 + 8'(off[3:0]);
                endcase
            end
            FMT_Q6_K: begin
                last_k = 3'd4;
                unique case (r_k)
                    3'd0:    rd_addr = 8'd208;
                    3'd1:    rd_addr = 8'd209;
                    3'd2:    rd_addr = {1'b0, r_e[7], sub6[0], off};
                    3'd3:    rd_addr = {2'b10, r_e[7], off};
                    default: rd_addr = {4'b1100, r_e[7], sub6, off[4]};
                endcase
            end
            default: begin
                last_k = 3'd7;
                unique case (r_k)
                    3'd0:    rd_addr = 8'd0;
                    3'd1:    rd_addr = 8'd1;
                    3'd2:    rd_addr = 8'd2;
                    3'd3:    rd_addr = 8'd3;
                    3'd4:    rd_addr = 8'd16 + {1'b0, sb4[2:1], off};
                    3'd5:    rd_addr = 8'd4 + 8'(sb4);
                    3'd6:    rd_addr = 8'd8 + 8'(sb4);
                    default: rd_addr = 8'(sb4);
                endcase
            end
        endcase
    end

    // byte store: a write port and a separate registered read port
    always_ff @(posedge i_clk) begin
        if (acc_in && !s_axis_tuser[0] && (9'(s_axis_tdata[7:0]) < 9'(BLOCK_BYTES))) begin
            r_mem[s_axis_tdata[AW-1:0]] <= s_axis_tdata[15:8];
        end
        r_rdata <= r_mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= (r_state == ST_FETCH);
        end
        r_fk <= r_k;
        if (r_fv) r_b[r_fk] <= r_rdata;
        if (acc_in) r_e <= s_axis_tdata[23:16];
    end

    // operand decode from the fetched bytes
    always_comb begin
        dh   = {r_b[1], r_b[0]};
        dm   = {r_b[3], r_b[2]};
        nib4 = sb4[0] ? r_b[4][7:4] : r_b[4][3:0];
        if (!sb4[2]) begin
            sc4 = r_b[5][5:0];
            m4  = r_b[6][5:0];
        end else begin
            sc4 = {r_b[7][7:6], r_b[6][3:0]};
            m4  = {r_b[5][7:6], r_b[6][7:4]};
        end
        x1 = '0;
        x2 = 9'(m4);
        unique case (r_fmt)
            FMT_Q8_0: x0 = 9'(signed'(r_b[2]));
            FMT_Q5_0: x0 = 9'({r_b[2][off[2:0]],
                               off[4] ? r_b[3][7:4] : r_b[3][3:0]}) - 9'sd16;
            FMT_Q6_K: begin
                x0 = 9'(signed'(r_b[4]));
                x1 = 9'({r_b[3][{sub6, 1'b0} +: 2],
                         sub6[1] ? r_b[2][7:4] : r_b[2][3:0]}) - 9'sd32;
            end
            default: begin
                x0 = 9'(sc4);
                x1 = 9'(nib4);
            end
        endcase
    end

    always_comb begin
        unique case (r_c)
            2'd0: begin f_op = FOP_MUL; f_a = half_to_f32(dh); f_b = int_to_f32(x0); end
            2'd1: begin f_op = FOP_MUL; f_a = r_acc;           f_b = int_to_f32(x1); end
            2'd2: begin f_op = FOP_MUL; f_a = half_to_f32(dm); f_b = int_to_f32(x2); end
            default: begin f_op = FOP_SUB; f_a = r_acc;        f_b = r_tmp;          end
        endcase
    end

    qbd_fpu u_fpu (
        .i_op (f_op),
        .i_a  (f_a),
        .i_b  (f_b),
        .o_y  (f_y)
    );

    assign last_c = (r_c == 2'd3)
                 || ((r_fmt == FMT_Q8_0 || r_fmt == FMT_Q5_0) && r_c == 2'd0)
                 || ((r_fmt == FMT_Q6_K) && r_c == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_c     <= n_c;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_c     = r_c;
        unique case (r_state)
            ST_IDLE: begin
                n_k = '0;
                n_c = '0;
                if (acc_in && s_axis_tuser[0]) n_state = ST_FETCH;
            end
            ST_FETCH: begin
                if (r_k == last_k) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_DRAIN: n_state = ST_CALC;
            ST_CALC: begin
                if (!last_c) begin
                    n_c = r_c + 2'd1;
                end else if (!r_ovalid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // the last step feeds the output register only, so its operands hold while stalled
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC && !last_c) begin
            if (r_c == 2'd2) begin
                r_tmp <= f_y;
            end else begin
                r_acc <= f_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_CALC && last_c && (!r_ovalid || m_axis_tready)) begin
            r_ovalid <= 1'b1;
        end else if (acc_out) begin
            r_ovalid <= 1'b0;
        end
        if (r_state == ST_CALC && last_c && (!r_ovalid || m_axis_tready)) begin
            r_odata <= f_y;
        end
    end

    a_read_starts_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && s_axis_tuser[0]) |=> (r_state == ST_FETCH && r_k == 3'd0))
        else $error("read request did not start a fetch");

    a_fetch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (r_k <= last_k))
        else $error("fetch slot beyond the layout");

    a_short_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC && (r_fmt == FMT_Q8_0 || r_fmt == FMT_Q5_0)) |-> (r_c == 2'd0))
        else $error("extra float step for a 32-element layout");

    a_result_from_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == ST_CALC))
        else $error("result raised outside the compute phase");

endmodule

`default_nettype wire

// ===== src/qbd_fpu.sv =====
// Shared single-precision multiply / subtract unit, round to nearest even.
// Depends on qbd_pkg. Operands are zero, normal, infinity or NaN.
`default_nettype none

module qbd_fpu
    import qbd_pkg::*;
(
    input  var t_fpu_op     i_op,
    input  wire     [31:0]  i_a,
    input  wire     [31:0]  i_b,
    output logic    [31:0]  o_y
);

    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    // multiply path
    logic [47:0] prod;
    logic [23:0] pm24;
    logic        pg, pst;
    logic [24:0] pm25;
    logic [9:0]  pe;
    logic [31:0] mul_y;

    // subtract path
    logic        sbe, a_big, s_big;
    logic [7:0]  e_big;
    logic [23:0] m_big, m_sml;
    logic [7:0]  diff;
    logic [5:0]  sh_amt;
    logic [74:0] op_a, op_b, sum, nrm;
    logic [6:0]  lz;
    logic [23:0] am24;
    logic        ag, ast;
    logic [24:0] am25;
    logic [9:0]  ae;
    logic [31:0] sub_y;

    always_comb begin
        sa     = i_a[31];
        sb     = i_b[31];
        ea     = i_a[30:23];
        eb     = i_b[30:23];
        ma     = {1'b1, i_a[22:0]};
        mb     = {1'b1, i_b[22:0]};
        a_nan  = (ea == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan  = (eb == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf  = (ea == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf  = (eb == 8'hFF) && (i_b[22:0] == 23'd0);
        a_zero = (ea == 8'd0);
        b_zero = (eb == 8'd0);

        // ---------------- multiply
        prod = ma * mb;
        if (prod[47]) begin
            pm24 = prod[47:24];
            pg   = prod[23];
            pst  = |prod[22:0];
        end else begin
            pm24 = prod[46:23];
            pg   = prod[22];
            pst  = |prod[21:0];
        end
        pm25 = {1'b0, pm24} + 25'(pg & (pst | pm24[0]));
        pe   = 10'(ea) + 10'(eb) - 10'd127 + 10'(prod[47]) + 10'(pm25[24]);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            mul_y = F32_QNAN;
        end else if (a_inf || b_inf || (pe >= 10'd255 && !pe[9])) begin
            mul_y = {sa ^ sb, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            mul_y = {sa ^ sb, 31'd0};
        end else begin
            mul_y = {sa ^ sb, pe[7:0], pm25[24] ? pm25[23:1] : pm25[22:0]};
        end

        // ---------------- subtract: a + (-b)
        sbe    = ~sb;
        a_big  = {ea, i_a[22:0]} >= {eb, i_b[22:0]};
        e_big  = a_big ? ea : eb;
        m_big  = a_big ? ma : mb;
        m_sml  = a_big ? mb : ma;
        s_big  = a_big ? sa : sbe;
        diff   = a_big ? 8'(ea - eb) : 8'(eb - ea);
        // beyond 50 places the smaller operand only feeds the sticky bit
        sh_amt = (diff > 8'd50) ? 6'd50 : diff[5:0];
        op_a   = {1'b0, m_big, 50'd0};
        op_b   = {1'b0, m_sml, 50'd0} >> sh_amt;
        sum    = (sa != sbe) ? (op_a - op_b) : (op_a + op_b);
        lz     = '0;
        for (int i = 0; i < 75; i++) begin
            if (sum[i]) lz = 7'(74 - i);
        end
        nrm  = sum << lz;
        am24 = nrm[74:51];
        ag   = nrm[50];
        ast  = |nrm[49:0];
        am25 = {1'b0, am24} + 25'(ag & (ast | am24[0]));
        ae   = 10'(e_big) + 10'd1 - 10'(lz) + 10'(am25[24]);
        if (a_nan || b_nan || (a_inf && b_inf && (sa != sbe))) begin
            sub_y = F32_QNAN;
        end else if (a_inf) begin
            sub_y = i_a;
        end else if (b_inf) begin
            sub_y = {sbe, 8'hFF, 23'd0};
        end else if (a_zero && b_zero) begin
            sub_y = {sa & sbe, 31'd0};
        end else if (a_zero) begin
            sub_y = {sbe, i_b[30:0]};
        end else if (b_zero) begin
            sub_y = i_a;
        end else if (sum == 75'd0) begin
            sub_y = F32_ZERO;
        end else if (ae >= 10'd255 && !ae[9]) begin
            sub_y = {s_big, 8'hFF, 23'd0};
        end else begin
            sub_y = {s_big, ae[7:0], am25[24] ? am25[23:1] : am25[22:0]};
        end

        unique case (i_op)
            FOP_MUL: o_y = mul_y;
            FOP_SUB: o_y = sub_y;
            default: o_y = mul_y;
        endcase
    end

endmodule

`default_nettype wire
